FILE: hdl/rlbd_pkg.sv
// ----------------------------------------------------------------------------
// rlbd_pkg
// Shared types, constants and helpers for the resistor ladder button decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlbd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_BUTTONS_DEF = 16;
  localparam int FULL_SCALE_DEF  = 1023;

  // Hysteresis is one tenth of the ladder step
  localparam int HYST_DIVISOR = 10;

  // Divide by ten as multiply and shift, exact for any 16-bit step
  localparam logic [31:0] HYST_RECIP = 32'd52429;
  localparam int          HYST_SHIFT = 19;

  // Fixed field widths
  localparam int SAMPLE_W = 10;
  localparam int CNT_W    = 5;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One accepted sample on its way to the back end
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]    query_button;
  } item_t;

  // Front: step divide, hysteresis multiply, then open for samples
  typedef enum logic [1:0] {
    F_STEP,
    F_HYST,
    F_READY
  } front_state_t;

  // Back: wait for an item, or walk the ladder levels
  typedef enum logic {
    B_IDLE,
    B_SEARCH
  } back_state_t;

  // Zero count acts as one, counts above the limit are clamped
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw,
                                                 input int max_b);
    logic [CNT_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = CNT_W'(1);
    end else if (int'(raw) > max_b) begin
      res = CNT_W'(max_b);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/resistor_ladder_button_decoder.sv
// ----------------------------------------------------------------------------
// resistor_ladder_button_decoder
// Decodes the pressed button of a resistor ladder keypad from converter
// samples, with hysteresis around the last accepted level.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall  in_sample, in_query_button
//  out_      output     out_valid/out_stall  out_not_selected, out_active_button
//  cfg_      input      cfg_we               cfg_wdata (button count)
//
//  A sample inside the hysteresis band needs no search in the back end; one
//  outside it starts a ladder search, one ladder level per cycle.
//  After reset and after each count write, the step is derived by a
//  bit-serial divider and then the hysteresis by a multiply, while
//  in_stall is high. Reset is synchronous, active low.
//  A two-entry queue keeps input transfers going while a result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module resistor_ladder_button_decoder
  import rlbd_pkg::*;
#(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int FULL_SCALE  = FULL_SCALE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CNT_W-1:0]    cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [CNT_W-1:0]    in_query_button,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_not_selected,
  output logic [CNT_W-1:0]         out_active_button
);

  localparam int QW = $clog2(FULL_SCALE + 1);

  logic             push;
  item_t            push_item;
  logic             q_full;
  logic             q_valid;
  item_t            q_item;
  logic             pop;
  logic [CNT_W-1:0] count;
  logic [QW-1:0]    step;
  logic [QW-1:0]    hyst;

  // Accept, count register and step/hysteresis derivation
  rlbd_front #(
    .MAX_BUTTONS (MAX_BUTTONS),
    .FULL_SCALE  (FULL_SCALE)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_query_button (in_query_button),
    .push_o          (push),
    .push_item_o     (push_item),
    .q_full_i        (q_full),
    .count_o         (count),
    .step_o          (step),
    .hyst_o          (hyst)
  );

  // Sample queue
  rlbd_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (pop)
  );

  // Decode and result stage
  rlbd_back #(
    .FULL_SCALE (FULL_SCALE)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .count_i           (count),
    .step_i            (step),
    .hyst_i            (hyst),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .pop_o             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_not_selected  (out_not_selected),
    .out_active_button (out_active_button)
  );

endmodule

`default_nettype wire

FILE: hdl/rlbd_front.sv
// ----------------------------------------------------------------------------
// rlbd_front
// Holds the button count, derives the step with a restoring divider and the
// hysteresis with a reciprocal multiply, and pushes accepted samples into
// the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbd_front
  import rlbd_pkg::*;
#(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int FULL_SCALE  = FULL_SCALE_DEF,
  localparam int QW = $clog2(FULL_SCALE + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [CNT_W-1:0]    cfg_wdata,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [CNT_W-1:0]    in_query_button,
  // queue write side
  output logic                     push_o,
  output item_t                    push_item_o,
  input  wire logic                q_full_i,
  // derived ladder settings
  output logic [CNT_W-1:0]         count_o,
  output logic [QW-1:0]            step_o,
  output logic [QW-1:0]            hyst_o
);

  localparam int IW = (QW > 1) ? $clog2(QW) : 1;

  front_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] div_r, div_nxt;
  logic [IW-1:0]    iter_r, iter_nxt;
  logic [QW-1:0]    step_r, step_nxt;
  logic [QW-1:0]    hyst_r, hyst_nxt;

  logic [CNT_W:0]   trial;
  logic             ge;
  logic [QW-1:0]    quo_step;
  logic [CNT_W-1:0] rem_step;
  logic             last_iter;
  logic [31:0]      hyst_prod;

  // One restoring division step: one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[QW-1]};
    ge       = (trial >= {1'b0, div_r});
    rem_step = ge ? CNT_W'(trial - {1'b0, div_r}) : trial[CNT_W-1:0];
    quo_step = {quo_r[QW-2:0], ge};
    last_iter = (iter_r == IW'(QW - 1));
  end

  // step / 10 from the registered step
  assign hyst_prod = 32'(step_r) * HYST_RECIP;

  // Sequencer: step = FULL_SCALE / count, then hyst = step / 10
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    iter_nxt  = iter_r;
    step_nxt  = step_r;
    hyst_nxt  = hyst_r;

    unique case (state_r)
      F_STEP: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        iter_nxt = iter_r + IW'(1);
        if (last_iter) begin
          step_nxt  = quo_step;
          iter_nxt  = '0;
          state_nxt = F_HYST;
        end
      end
      F_HYST: begin
        hyst_nxt  = QW'(hyst_prod >> HYST_SHIFT);
        state_nxt = F_READY;
      end
      F_READY: begin
      end
      default: begin
        state_nxt = F_STEP;
      end
    endcase

    // A new count restarts the derivation
    if (cfg_we) begin
      cnt_nxt   = cfg_wdata;
      quo_nxt   = QW'(FULL_SCALE);
      rem_nxt   = '0;
      div_nxt   = eff_count(cfg_wdata, MAX_BUTTONS);
      iter_nxt  = '0;
      state_nxt = F_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_STEP;
      cnt_r   <= CNT_W'(1);
      quo_r   <= QW'(FULL_SCALE);
      rem_r   <= '0;
      div_r   <= eff_count(CNT_W'(1), MAX_BUTTONS);
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      quo_r   <= quo_nxt;
      rem_r   <= rem_nxt;
      div_r   <= div_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // Derived settings are payload, valid once the sequencer is ready
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    hyst_r <= hyst_nxt;
  end

  // Input transfer goes straight into the queue
  assign in_stall    = (state_r != F_READY) || q_full_i;
  assign push_o      = in_valid && !in_stall;
  assign push_item_o = '{sample: in_sample, query_button: in_query_button};

  assign count_o = eff_count(cnt_r, MAX_BUTTONS);
  assign step_o  = step_r;
  assign hyst_o  = hyst_r;

`ifndef NO_ASSERTIONS
  // Hysteresis never exceeds the step once derived
  a_hyst_le_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_READY && $past(state_r) == F_HYST) |-> (hyst_r <= step_r))
    else $error("hysteresis larger than step");
`endif

endmodule

`default_nettype wire

FILE: hdl/rlbd_queue.sv
// ----------------------------------------------------------------------------
// rlbd_queue
// Short FIFO of accepted samples between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbd_queue
  import rlbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_i,
  input  item_t      push_item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  item_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;

  // Pointer advance with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_i && !pop_i) begin
      fill_nxt = fill_r + FW'(1);
    end else if (!push_i && pop_i) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= push_item_i;
    end
  end

  assign full_o  = (fill_r == FW'(QUEUE_DEPTH));
  assign valid_o = (fill_r != '0);
  assign item_o  = entry_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  // No write into a full queue without a read, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o && !pop_i))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o)
    else $error("queue underflow");
`endif

endmodule

`default_nettype wire

FILE: hdl/rlbd_back.sv
// ----------------------------------------------------------------------------
// rlbd_back
// Hysteresis check against the held level, ladder search one button per
// cycle, and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbd_back
  import rlbd_pkg::*;
#(
  parameter int FULL_SCALE = FULL_SCALE_DEF,
  localparam int QW = $clog2(FULL_SCALE + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // ladder settings
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic [QW-1:0]    step_i,
  input  wire logic [QW-1:0]    hyst_i,
  // queue read side
  input  wire logic             q_valid_i,
  input  item_t                 q_item_i,
  output logic                  pop_o,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_not_selected,
  output logic [CNT_W-1:0]      out_active_button
);

  localparam int LW = (QW > SAMPLE_W) ? QW : SAMPLE_W;
  localparam int CW = LW + 1;

  back_state_t         state_r, state_nxt;
  logic [SAMPLE_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]    dec_r, dec_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CW-1:0]       nom_r, nom_nxt;
  logic [CNT_W-1:0]    query_r, query_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ns_r, out_ns_nxt;
  logic [CNT_W-1:0]    out_ab_r, out_ab_nxt;

  logic                out_free;
  logic [CW-1:0]       samp_w, held_w, hyst_w, step_w;
  logic                leave_band;
  logic                level_hit;
  logic [CNT_W-1:0]    found;

  // Band tests, all in a widened unsigned domain
  always_comb begin
    samp_w     = CW'(q_item_i.sample);
    held_w     = CW'(held_r);
    hyst_w     = CW'(hyst_i);
    step_w     = CW'(step_i);
    leave_band = (samp_w + hyst_w < held_w) || (held_w + hyst_w < samp_w);
    level_hit  = (nom_r <= held_w + hyst_w) && (held_w <= nom_r + hyst_w);
  end

  assign out_free = !out_valid_r || !out_stall;

  // Decode sequencer
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    dec_nxt       = dec_r;
    k_nxt         = k_r;
    nom_nxt       = nom_r;
    query_nxt     = query_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ns_nxt    = out_ns_r;
    out_ab_nxt    = out_ab_r;
    pop_o         = 1'b0;
    found         = '0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          if (leave_band) begin
            // Held level jumps to the sample, walk the ladder from button 1
            held_nxt  = q_item_i.sample;
            dec_nxt   = '0;
            k_nxt     = CNT_W'(1);
            nom_nxt   = step_w;
            query_nxt = q_item_i.query_button;
            state_nxt = B_SEARCH;
          end else begin
            out_valid_nxt = 1'b1;
            out_ab_nxt    = dec_r;
            out_ns_nxt    = (dec_r != q_item_i.query_button);
          end
        end
      end
      B_SEARCH: begin
        if (level_hit || k_r == count_i) begin
          found         = level_hit ? k_r : '0;
          dec_nxt       = found;
          out_valid_nxt = 1'b1;
          out_ab_nxt    = found;
          out_ns_nxt    = (found != query_r);
          state_nxt     = B_IDLE;
        end else begin
          k_nxt   = k_r + CNT_W'(1);
          nom_nxt = nom_r + step_w;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      held_r      <= '0;
      dec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Search and result payload
  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    nom_r    <= nom_nxt;
    query_r  <= query_nxt;
    out_ns_r <= out_ns_nxt;
    out_ab_r <= out_ab_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_not_selected  = out_ns_r;
  assign out_active_button = out_ab_r;

`ifndef NO_ASSERTIONS
  // The result stage is empty for the whole search
  a_search_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SEARCH) |-> !out_valid_r)
    else $error("result pending during search");
  // Search index stays within 1..count
  a_search_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SEARCH) |-> (k_r != '0 && k_r <= count_i))
    else $error("search index out of range");
`endif

endmodule

`default_nettype wire
